// ----- design/ilp_pkg.sv -----
// ilp_pkg: types and character constants for the integer literal parser
// used by ilp_step and integer_literal_parser; depends on nothing else
`default_nettype none

package ilp_pkg;

  // parser phase
  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_ZERO = 2'd1,
    PH_DEC  = 2'd2,
    PH_HEX  = 2'd3
  } phase_e;

  localparam int unsigned ValueW = 64;
  localparam int unsigned CharW  = 8;
  localparam int unsigned DigitW = 4;

  // character codes
  localparam logic [CharW-1:0] ChNul    = 8'h00;
  localparam logic [CharW-1:0] ChTab    = 8'h09;
  localparam logic [CharW-1:0] ChCr     = 8'h0D;
  localparam logic [CharW-1:0] ChSpace  = 8'h20;
  localparam logic [CharW-1:0] ChPlus   = 8'h2B;
  localparam logic [CharW-1:0] ChMinus  = 8'h2D;
  localparam logic [CharW-1:0] ChZero   = 8'h30;
  localparam logic [CharW-1:0] ChOne    = 8'h31;
  localparam logic [CharW-1:0] ChNine   = 8'h39;
  localparam logic [CharW-1:0] ChUpA    = 8'h41;
  localparam logic [CharW-1:0] ChUpF    = 8'h46;
  localparam logic [CharW-1:0] ChUpX    = 8'h58;
  localparam logic [CharW-1:0] ChLowA   = 8'h61;
  localparam logic [CharW-1:0] ChLowF   = 8'h66;
  localparam logic [CharW-1:0] ChLowX   = 8'h78;
  localparam logic [CharW-1:0] LetterOfs = 8'd10;

  // parser state carried between characters
  typedef struct packed {
    phase_e              phase;
    logic [ValueW-1:0]   acc;
    logic                neg;
  } state_t;

  // result produced when a number ends
  typedef struct packed {
    logic                vld;
    logic [ValueW-1:0]   value;
    logic                success;
    logic                pushed;
  } result_t;

endpackage

`default_nettype wire

// ----- design/ilp_step.sv -----
// ilp_step: next-state and result logic for one character of the parser
// depends on ilp_pkg
`default_nettype none

module ilp_step
  import ilp_pkg::*;
(
  input  state_t             st_i,
  input  logic [CharW-1:0]   char_i,
  input  logic               eoi_i,
  output state_t             st_o,
  output result_t            res_o
);

  logic               is_end;
  logic               is_space;
  logic               is_dec;
  logic               is_hex;
  logic [DigitW-1:0]  dig;
  logic [ValueW-1:0]  acc_dec;
  logic [ValueW-1:0]  acc_hex;
  logic [ValueW-1:0]  signed_val;
  logic               fin;
  logic               ok;
  logic               push;

  // character classes
  always_comb begin
    is_end   = eoi_i || (char_i == ChNul);
    is_space = (char_i == ChSpace) || (char_i inside {[ChTab:ChCr]});
    is_dec   = char_i inside {[ChZero:ChNine]};
    is_hex   = is_dec || (char_i inside {[ChLowA:ChLowF]}) ||
               (char_i inside {[ChUpA:ChUpF]});
    if (char_i inside {[ChLowA:ChLowF]}) begin
      dig = DigitW'(char_i - ChLowA + LetterOfs);
    end else if (char_i inside {[ChUpA:ChUpF]}) begin
      dig = DigitW'(char_i - ChUpA + LetterOfs);
    end else begin
      dig = DigitW'(char_i - ChZero);
    end
  end

  // accumulate: times ten as shift-add, times sixteen as shift
  assign acc_dec = {st_i.acc[ValueW-4:0], 3'b000} + {st_i.acc[ValueW-2:0], 1'b0}
                 + ValueW'(dig);
  assign acc_hex = {st_i.acc[ValueW-DigitW-1:0], dig};

  // phase transitions and termination
  always_comb begin
    st_o = st_i;
    fin  = 1'b0;
    ok   = 1'b0;
    push = 1'b0;
    case (st_i.phase)
      PH_IDLE: begin
        if (is_end) begin
          fin = 1'b1;
        end else if (is_space || char_i == ChPlus) begin
          st_o = st_i;
        end else if (char_i == ChMinus) begin
          st_o.neg = ~st_i.neg;
        end else if (char_i == ChZero) begin
          st_o.phase = PH_ZERO;
        end else if (char_i inside {[ChOne:ChNine]}) begin
          st_o.acc   = ValueW'(dig);
          st_o.phase = PH_DEC;
        end else begin
          fin = 1'b1;
        end
      end
      PH_ZERO: begin
        if (is_end) begin
          fin = 1'b1;
          ok  = 1'b1;
        end else if (char_i == ChLowX || char_i == ChUpX) begin
          st_o.phase = PH_HEX;
        end else if (is_dec) begin
          st_o.acc   = ValueW'(dig);
          st_o.phase = PH_DEC;
        end else begin
          fin  = 1'b1;
          ok   = is_space;
          push = 1'b1;
        end
      end
      PH_DEC: begin
        if (is_end) begin
          fin = 1'b1;
          ok  = 1'b1;
        end else if (is_dec) begin
          st_o.acc = acc_dec;
        end else begin
          fin  = 1'b1;
          ok   = is_space;
          push = 1'b1;
        end
      end
      default: begin
        if (is_end) begin
          fin = 1'b1;
          ok  = 1'b1;
        end else if (is_hex) begin
          st_o.acc = acc_hex;
        end else begin
          fin  = 1'b1;
          ok   = is_space;
          push = 1'b1;
        end
      end
    endcase
    // a finished number returns the parser to its reset state
    if (fin) begin
      st_o.phase = PH_IDLE;
      st_o.acc   = '0;
      st_o.neg   = 1'b0;
    end
  end

  // apply sign, zero on failure
  assign signed_val    = st_i.neg ? (ValueW'(0) - st_i.acc) : st_i.acc;
  assign res_o.vld     = fin;
  assign res_o.value   = ok ? signed_val : '0;
  assign res_o.success = ok;
  assign res_o.pushed  = push;

endmodule

`default_nettype wire

// ----- design/integer_literal_parser.sv -----
// integer_literal_parser: top level, input register, parser state, result register
// depends on ilp_pkg and ilp_step
//
// Usage: one character arrives per request on the slave stream (tdata holds
// the byte, tlast marks end of input instead of a character; a NUL byte also
// ends the number). When a number ends, one request leaves on the master
// stream: tdata carries the signed 64-bit value, tuser carries success and
// whether the terminating byte was pushed back and must be sent again.
// Characters that do not end a number produce no output request.
// A result request is registered: the character that ends the number passes
// through the input register, then the result register.
// Throughput: one character per cycle while output is not stalled; the critical
// loop is the parser state register through the 64-bit times-ten shift-add.
// Reset: the parser returns to idle with a zero accumulator and positive
// sign, and both registers are empty.
// Stall: while the result register is full and not taken, the input
// register holds its character and tready drops once it is occupied;
// no request is lost or duplicated.
`default_nettype none

module integer_literal_parser
  import ilp_pkg::*;
(
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           s_axis_tvalid_i,
  output      logic           s_axis_tready_o,
  input  wire logic [7:0]     s_axis_tdata_i,   // [7:0] char_byte
  input  wire logic           s_axis_tlast_i,   // end_of_input
  output      logic           m_axis_tvalid_o,
  input  wire logic           m_axis_tready_i,
  output      logic [63:0]    m_axis_tdata_o,   // [63:0] value
  output      logic [1:0]     m_axis_tuser_o    // [0] success, [1] byte_pushed_back
);

  logic               in_vld_q;
  logic [CharW-1:0]   in_char_q;
  logic               in_eoi_q;
  logic               out_vld_q;
  logic [ValueW-1:0]  out_value_q;
  logic               out_success_q;
  logic               out_pushed_q;
  state_t             st_q;
  state_t             st_d;
  result_t            res;
  logic               advance;
  logic               s_acc;

  // a buffered character is processed when the result register can take it
  assign advance         = in_vld_q && (!out_vld_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_vld_q || advance;
  assign s_acc           = s_axis_tvalid_i && s_axis_tready_o;

  ilp_step u_step (
    .st_i   (st_q),
    .char_i (in_char_q),
    .eoi_i  (in_eoi_q),
    .st_o   (st_d),
    .res_o  (res)
  );

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      st_q      <= '{phase: PH_IDLE, acc: '0, neg: 1'b0};
    end else begin
      if (s_axis_tready_o) begin
        in_vld_q <= s_axis_tvalid_i;
      end
      if (advance) begin
        st_q      <= st_d;
        out_vld_q <= res.vld;
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      in_char_q <= s_axis_tdata_i;
      in_eoi_q  <= s_axis_tlast_i;
    end
    if (advance && res.vld) begin
      out_value_q   <= res.value;
      out_success_q <= res.success;
      out_pushed_q  <= res.pushed;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_value_q;
  assign m_axis_tuser_o  = {out_pushed_q, out_success_q};

  // a finished number leaves the parser in its reset state
  a_reset_after_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && res.vld |=> st_q.phase == PH_IDLE && st_q.acc == '0 && !st_q.neg)
    else $error("parser state not cleared after result");

  // a failed parse reports a zero value
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !out_success_q |-> out_value_q == '0)
    else $error("nonzero value on failure");

  // pushback only happens once a number has started
  a_push_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && res.vld && res.pushed |-> st_q.phase != PH_IDLE)
    else $error("pushback from idle phase");

  // an empty result register never blocks the input
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_vld_q |-> s_axis_tready_o)
    else $error("input stalled with empty result register");

endmodule

`default_nettype wire
